// ===== rtl/bale_pkg.sv =====
// Shared types, widths and command codes for the bounded array list engine.
`default_nettype none

package bale_pkg;

  localparam int CAPACITY_DEF = 128;
  localparam int KIND_W       = 3;
  localparam int HANDLE_W     = 16;
  localparam int PRICE_W      = 24;
  localparam int COUNT_W      = 8;
  localparam int POS_W        = 8;
  localparam int INDEX_W      = 7;
  localparam int LENGTH_W     = 8;

  typedef enum logic [KIND_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_REMOVE    = 3'd2,
    OP_SWAP      = 3'd3,
    OP_FIND_MIN  = 3'd4,
    OP_READ      = 3'd5
  } op_kind_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [PRICE_W-1:0]  price;
  } entry_t;

  // Memory read port: address source and pointer update
  typedef enum logic [2:0] {
    RD_NONE  = 3'd0,
    RD_LAST  = 3'd1,
    RD_PREV  = 3'd2,
    RD_FIRST = 3'd3,
    RD_NEXT  = 3'd4,
    RD_POS_A = 3'd5,
    RD_POS_B = 3'd6,
    RD_INDEX = 3'd7
  } rd_sel_t;

  // Memory write port: address and data source
  typedef enum logic [2:0] {
    WR_NONE   = 3'd0,
    WR_FRONT  = 3'd1,
    WR_BACK   = 3'd2,
    WR_SHIFT  = 3'd3,
    WR_SWAP_A = 3'd4,
    WR_SWAP_B = 3'd5
  } wr_sel_t;

  typedef enum logic [1:0] {
    LEN_HOLD   = 2'd0,
    LEN_INC    = 2'd1,
    LEN_REMOVE = 2'd2
  } len_op_t;

  typedef enum logic [1:0] {
    FOUND_NONE  = 2'd0,
    FOUND_MIN   = 2'd1,
    FOUND_RDATA = 2'd2
  } found_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_DECODE    = 4'd1,
    ST_SHIFT     = 4'd2,
    ST_FRONT_PUT = 4'd3,
    ST_SWAP_RB   = 4'd4,
    ST_SWAP_WA   = 4'd5,
    ST_SWAP_WB   = 4'd6,
    ST_SCAN      = 4'd7,
    ST_READ_OUT  = 4'd8
  } state_t;

  typedef struct packed {
    logic       load;
    rd_sel_t    rd_sel;
    wr_sel_t    wr_sel;
    logic       scan_step;
    logic       finish;
    logic       ok;
    len_op_t    len_op;
    found_sel_t found_sel;
  } dp_cmd_t;

  typedef struct packed {
    op_kind_t kind;
    logic     full;
    logic     empty;
    logic     swap_ok;
    logic     read_ok;
    logic     ptr_zero;
    logic     scan_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/bale_ctrl.sv =====
// Controller state machine: sequences memory accesses for each request.
`default_nettype none

module bale_ctrl
  import bale_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (status.kind)
          OP_INS_FRONT: begin
            if (status.full) begin
              cmd.finish = 1'b1;
              state_nxt  = ST_IDLE;
            end else if (status.empty) begin
              cmd.wr_sel = WR_FRONT;
              cmd.len_op = LEN_INC;
              cmd.ok     = 1'b1;
              cmd.finish = 1'b1;
              state_nxt  = ST_IDLE;
            end else begin
              cmd.rd_sel = RD_LAST;
              state_nxt  = ST_SHIFT;
            end
          end
          OP_INS_BACK: begin
            if (!status.full) begin
              cmd.wr_sel = WR_BACK;
              cmd.len_op = LEN_INC;
              cmd.ok     = 1'b1;
            end
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
          OP_REMOVE: begin
            if (!status.empty) begin
              cmd.len_op = LEN_REMOVE;
              cmd.ok     = 1'b1;
            end
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
          OP_SWAP: begin
            if (status.swap_ok) begin
              cmd.rd_sel = RD_POS_A;
              state_nxt  = ST_SWAP_RB;
            end else begin
              cmd.finish = 1'b1;
              state_nxt  = ST_IDLE;
            end
          end
          OP_FIND_MIN: begin
            if (status.empty) begin
              cmd.finish = 1'b1;
              state_nxt  = ST_IDLE;
            end else begin
              cmd.rd_sel = RD_FIRST;
              state_nxt  = ST_SCAN;
            end
          end
          OP_READ: begin
            if (status.read_ok) begin
              cmd.rd_sel = RD_INDEX;
              state_nxt  = ST_READ_OUT;
            end else begin
              cmd.finish = 1'b1;
              state_nxt  = ST_IDLE;
            end
          end
          default: begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        endcase
      end
      ST_SHIFT: begin
        cmd.wr_sel = WR_SHIFT;
        if (status.ptr_zero) begin
          state_nxt = ST_FRONT_PUT;
        end else begin
          cmd.rd_sel = RD_PREV;
        end
      end
      ST_FRONT_PUT: begin
        cmd.wr_sel = WR_FRONT;
        cmd.len_op = LEN_INC;
        cmd.ok     = 1'b1;
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SWAP_RB: begin
        cmd.rd_sel = RD_POS_B;
        state_nxt  = ST_SWAP_WA;
      end
      ST_SWAP_WA: begin
        cmd.wr_sel = WR_SWAP_A;
        state_nxt  = ST_SWAP_WB;
      end
      ST_SWAP_WB: begin
        cmd.wr_sel = WR_SWAP_B;
        cmd.ok     = 1'b1;
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          cmd.found_sel = FOUND_MIN;
          cmd.ok        = 1'b1;
          cmd.finish    = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.rd_sel = RD_NEXT;
        end
      end
      ST_READ_OUT: begin
        cmd.found_sel = FOUND_RDATA;
        cmd.ok        = 1'b1;
        cmd.finish    = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/bale_dpath.sv =====
// Datapath: entry memory, length counter, scan pointer and result registers.
`default_nettype none

module bale_dpath
  import bale_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dp_cmd_t             cmd,
  output dp_status_t               status,
  input  wire logic [KIND_W-1:0]   in_kind,
  input  wire logic [HANDLE_W-1:0] in_item_handle,
  input  wire logic [PRICE_W-1:0]  in_item_price,
  input  wire logic [COUNT_W-1:0]  in_remove_count,
  input  wire logic [POS_W-1:0]    in_position_a,
  input  wire logic [POS_W-1:0]    in_position_b,
  input  wire logic [INDEX_W-1:0]  in_read_index,
  output logic                     out_valid,
  output logic                     out_ok,
  output logic [HANDLE_W-1:0]      out_found_handle,
  output logic [PRICE_W-1:0]       out_found_price,
  output logic [LENGTH_W-1:0]      out_length,
  output logic                     out_is_empty,
  output logic                     out_is_full
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = (LW > POS_W) ? LW : POS_W;

  // Request operands, held for the whole request
  op_kind_t            kind_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [PRICE_W-1:0]  price_r;
  logic [COUNT_W-1:0]  count_r;
  logic [POS_W-1:0]    pa_r;
  logic [POS_W-1:0]    pb_r;
  logic [INDEX_W-1:0]  ridx_r;

  logic [LW-1:0] len_r;
  logic [LW-1:0] len_nxt;
  logic [AW-1:0] ptr_r;
  logic [AW-1:0] ptr_nxt;

  entry_t mem [CAPACITY];
  entry_t rdata_r;
  entry_t tmp_r;
  entry_t best_r;
  entry_t candidate;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        new_entry;

  logic [AW-1:0] pos_a_addr;
  logic [AW-1:0] pos_b_addr;
  logic [AW-1:0] last_addr;

  logic                out_valid_r;
  logic                out_ok_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic [PRICE_W-1:0]  out_price_r;
  logic [LENGTH_W-1:0] out_length_r;
  logic                out_empty_r;
  logic                out_full_r;

  assign new_entry.handle = handle_r;
  assign new_entry.price  = price_r;

  assign pos_a_addr = AW'(pa_r - POS_W'(1));
  assign pos_b_addr = AW'(pb_r - POS_W'(1));
  assign last_addr  = AW'(len_r - LW'(1));

  // Status towards the controller
  always_comb begin
    status.kind      = kind_r;
    status.full      = (len_r == LW'(CAPACITY));
    status.empty     = (len_r == '0);
    status.swap_ok   = (pa_r != '0) && (pb_r != '0) &&
                       (CW'(pa_r) <= CW'(len_r)) && (CW'(pb_r) <= CW'(len_r));
    status.read_ok   = (CW'(ridx_r) < CW'(len_r));
    status.ptr_zero  = (ptr_r == '0);
    status.scan_last = (ptr_r == last_addr);
  end

  // First entry of a scan, or a strictly lower price, takes the lead
  assign candidate = ((ptr_r == '0) || (rdata_r.price < best_r.price)) ? rdata_r : best_r;

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    ptr_nxt = ptr_r;
    case (cmd.rd_sel)
      RD_LAST: begin
        rd_addr = last_addr;
        ptr_nxt = last_addr;
      end
      RD_PREV: begin
        rd_addr = ptr_r - AW'(1);
        ptr_nxt = ptr_r - AW'(1);
      end
      RD_FIRST: begin
        rd_addr = '0;
        ptr_nxt = '0;
      end
      RD_NEXT: begin
        rd_addr = ptr_r + AW'(1);
        ptr_nxt = ptr_r + AW'(1);
      end
      RD_POS_A: rd_addr = pos_a_addr;
      RD_POS_B: rd_addr = pos_b_addr;
      RD_INDEX: rd_addr = AW'(ridx_r);
      default:  rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = '0;
    wr_data = new_entry;
    case (cmd.wr_sel)
      WR_FRONT: wr_addr = '0;
      WR_BACK:  wr_addr = AW'(len_r);
      WR_SHIFT: begin
        wr_addr = ptr_r + AW'(1);
        wr_data = rdata_r;
      end
      WR_SWAP_A: begin
        wr_addr = pos_a_addr;
        wr_data = rdata_r;
      end
      WR_SWAP_B: begin
        wr_addr = pos_b_addr;
        wr_data = tmp_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd.len_op)
      LEN_INC:    len_nxt = len_r + LW'(1);
      LEN_REMOVE: len_nxt = (CW'(count_r) >= CW'(len_r)) ? '0 : len_r - LW'(count_r);
      default:    len_nxt = len_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= op_kind_t'(in_kind);
      handle_r <= in_item_handle;
      price_r  <= in_item_price;
      count_r  <= in_remove_count;
      pa_r     <= in_position_a;
      pb_r     <= in_position_b;
      ridx_r   <= in_read_index;
    end
    ptr_r <= ptr_nxt;
    if (cmd.rd_sel == RD_POS_B) begin
      tmp_r <= rdata_r;
    end
    if (cmd.scan_step) begin
      best_r <= candidate;
    end
    if (cmd.finish) begin
      out_ok_r     <= cmd.ok;
      out_length_r <= LENGTH_W'(len_nxt);
      out_empty_r  <= (len_nxt == '0);
      out_full_r   <= (len_nxt == LW'(CAPACITY));
      case (cmd.found_sel)
        FOUND_MIN: begin
          out_handle_r <= candidate.handle;
          out_price_r  <= candidate.price;
        end
        FOUND_RDATA: begin
          out_handle_r <= rdata_r.handle;
          out_price_r  <= rdata_r.price;
        end
        default: begin
          out_handle_r <= '0;
          out_price_r  <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_found_handle = out_handle_r;
  assign out_found_price  = out_price_r;
  assign out_length       = out_length_r;
  assign out_is_empty     = out_empty_r;
  assign out_is_full      = out_full_r;

endmodule

`default_nettype wire

// ===== rtl/bounded_array_list_engine_unit.sv =====
// Top level of the bounded array list engine: controller plus datapath.
`default_nettype none

// An ordered list of up to CAPACITY entries (16-bit handle, 24-bit price key)
// held in a simple dual-port memory: one write and one registered read per
// cycle. A request is taken at a clock edge where start is high and busy is
// low; busy then stays high until the request is finished, and exactly one
// result follows, shown for one cycle with out_valid high. The receiver
// cannot hold results off, so sample them in that cycle. busy is already low
// while the result is shown, so the next request may be issued alongside it.
// Step by step: insert at front makes one memory move per stored entry,
// then writes the new head (into an empty list it writes the head at once);
// find-min makes one memory read per stored entry; swap makes two reads,
// then two writes; read makes one read; insert at back, remove and every
// refused request finish straight from decode. The entry memory is not
// cleared at reset: only stored positions are ever read. Codes six and
// seven of in_kind are refused without change.

module bounded_array_list_engine_unit
  import bale_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [KIND_W-1:0]   in_kind,
  input  wire logic [HANDLE_W-1:0] in_item_handle,
  input  wire logic [PRICE_W-1:0]  in_item_price,
  input  wire logic [COUNT_W-1:0]  in_remove_count,
  input  wire logic [POS_W-1:0]    in_position_a,
  input  wire logic [POS_W-1:0]    in_position_b,
  input  wire logic [INDEX_W-1:0]  in_read_index,
  output logic                     out_valid,
  output logic                     out_ok,
  output logic [HANDLE_W-1:0]      out_found_handle,
  output logic [PRICE_W-1:0]       out_found_price,
  output logic [LENGTH_W-1:0]      out_length,
  output logic                     out_is_empty,
  output logic                     out_is_full
);

  // Commands flow down to the datapath, status flows back up
  dp_cmd_t    cmd;
  dp_status_t status;

  bale_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // Hold operands, memory and the result registers
  bale_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_kind          (in_kind),
    .in_item_handle   (in_item_handle),
    .in_item_price    (in_item_price),
    .in_remove_count  (in_remove_count),
    .in_position_a    (in_position_a),
    .in_position_b    (in_position_b),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_ok           (out_ok),
    .out_found_handle (out_found_handle),
    .out_found_price  (out_found_price),
    .out_length       (out_length),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full)
  );

endmodule

`default_nettype wire

// ===== rtl/bale_checker.sv =====
// Port-level checks for the bounded array list engine, bound to the top level.
`default_nettype none

module bale_checker
  import bale_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire logic                out_ok,
  input wire logic [HANDLE_W-1:0] out_found_handle,
  input wire logic [PRICE_W-1:0]  out_found_price,
  input wire logic [LENGTH_W-1:0] out_length,
  input wire logic                out_is_empty
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but busy did not rise");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_found_handle == '0 && out_found_price == '0))
    else $error("refused request carries found data");

  a_empty_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_length == '0))
    else $error("empty flag with non-zero length");

endmodule

bind bounded_array_list_engine_unit bale_checker u_bale_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_ok           (out_ok),
  .out_found_handle (out_found_handle),
  .out_found_price  (out_found_price),
  .out_length       (out_length),
  .out_is_empty     (out_is_empty)
);

`default_nettype wire

// ===== tb/bounded_array_list_engine_unit_tb.sv =====
// Self-checking testbench for the bounded array list engine: directed and random requests.
module bounded_array_list_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bale_pkg::*;

  localparam int CAPACITY        = CAPACITY_DEF;
  localparam int HALF_PERIOD_NS  = 2;
  localparam int RESET_CYCLES    = 9;
  localparam int MAX_GAP         = 10;
  localparam int RANDOM_REQUESTS = 2000;
  // Longest request is a front insert into a list one short of full.
  localparam int SETTLE_CYCLES   = CAPACITY + 8;
  localparam int STALL_LIMIT     = 8 * (CAPACITY + 3 + MAX_GAP);

  // Kind codes the block does not implement: refused, list untouched.
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle;
    logic [PRICE_W-1:0]  price;
    logic [COUNT_W-1:0]  remove_count;
    logic [POS_W-1:0]    pos_a;
    logic [POS_W-1:0]    pos_b;
    logic [INDEX_W-1:0]  read_index;
  } list_request_t;

  typedef struct {
    logic                ok;
    logic [HANDLE_W-1:0] found_handle;
    logic [PRICE_W-1:0]  found_price;
    logic [LENGTH_W-1:0] length;
    logic                is_empty;
    logic                is_full;
    time                 issued_at;
  } list_result_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [KIND_W-1:0]   in_kind;
  logic [HANDLE_W-1:0] in_item_handle;
  logic [PRICE_W-1:0]  in_item_price;
  logic [COUNT_W-1:0]  in_remove_count;
  logic [POS_W-1:0]    in_position_a;
  logic [POS_W-1:0]    in_position_b;
  logic [INDEX_W-1:0]  in_read_index;
  logic                out_valid;
  logic                out_ok;
  logic [HANDLE_W-1:0] out_found_handle;
  logic [PRICE_W-1:0]  out_found_price;
  logic [LENGTH_W-1:0] out_length;
  logic                out_is_empty;
  logic                out_is_full;

  // Shadow copy of the list, advanced once per accepted request.
  logic [HANDLE_W-1:0] shadow_handle [CAPACITY];
  logic [PRICE_W-1:0]  shadow_price  [CAPACITY];
  int unsigned         shadow_count;

  list_result_t pending_outcomes[$];
  int           issued_total   = 0;
  int           checked_total  = 0;
  int           mismatch_count = 0;
  int           stall_cycles   = 0;
  bit           back_to_back   = 1'b0;

  bounded_array_list_engine_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_item_handle   (in_item_handle),
    .in_item_price    (in_item_price),
    .in_remove_count  (in_remove_count),
    .in_position_a    (in_position_a),
    .in_position_b    (in_position_b),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_ok           (out_ok),
    .out_found_handle (out_found_handle),
    .out_found_price  (out_found_price),
    .out_length       (out_length),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full)
  );

  always #(HALF_PERIOD_NS) clk = ~clk;

  // Apply one request to the shadow list and return the result it must produce.
  function automatic list_result_t apply_list_op(input list_request_t rq);
    list_result_t res;
    int unsigned  best;
    logic [HANDLE_W-1:0] keep_handle;
    logic [PRICE_W-1:0]  keep_price;
    res.ok           = 1'b0;
    res.found_handle = '0;
    res.found_price  = '0;
    res.issued_at    = 0;
    case (rq.kind)
      OP_INS_FRONT: begin
        if (shadow_count < CAPACITY) begin
          // Shift every stored entry up one place, then write the new head.
          for (int i = int'(shadow_count); i > 0; i--) begin
            shadow_handle[i] = shadow_handle[i-1];
            shadow_price[i]  = shadow_price[i-1];
          end
          shadow_handle[0] = rq.handle;
          shadow_price[0]  = rq.price;
          shadow_count++;
          res.ok = 1'b1;
        end
      end
      OP_INS_BACK: begin
        if (shadow_count < CAPACITY) begin
          shadow_handle[shadow_count] = rq.handle;
          shadow_price[shadow_count]  = rq.price;
          shadow_count++;
          res.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (shadow_count != 0) begin
          shadow_count = (rq.remove_count >= shadow_count) ? 0 : shadow_count - rq.remove_count;
          res.ok = 1'b1;
        end
      end
      OP_SWAP: begin
        if (shadow_count != 0 && rq.pos_a >= 1 && rq.pos_b >= 1 &&
            rq.pos_a <= shadow_count && rq.pos_b <= shadow_count) begin
          keep_handle = shadow_handle[rq.pos_a-1];
          keep_price  = shadow_price[rq.pos_a-1];
          shadow_handle[rq.pos_a-1] = shadow_handle[rq.pos_b-1];
          shadow_price[rq.pos_a-1]  = shadow_price[rq.pos_b-1];
          shadow_handle[rq.pos_b-1] = keep_handle;
          shadow_price[rq.pos_b-1]  = keep_price;
          res.ok = 1'b1;
        end
      end
      OP_FIND_MIN: begin
        if (shadow_count != 0) begin
          // Strict less-than keeps the first of equal prices.
          best = 0;
          for (int i = 1; i < int'(shadow_count); i++) begin
            if (shadow_price[i] < shadow_price[best]) best = i;
          end
          res.found_handle = shadow_handle[best];
          res.found_price  = shadow_price[best];
          res.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (rq.read_index < shadow_count) begin
          res.found_handle = shadow_handle[rq.read_index];
          res.found_price  = shadow_price[rq.read_index];
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.length   = shadow_count[LENGTH_W-1:0];
    res.is_empty = (shadow_count == 0);
    res.is_full  = (shadow_count == CAPACITY);
    return res;
  endfunction

  // Every field random over its full width; callers then pin what matters.
  function automatic list_request_t scrambled_request(input logic [KIND_W-1:0] kind);
    list_request_t rq;
    rq.kind         = kind;
    rq.handle       = HANDLE_W'($urandom);
    rq.price        = PRICE_W'($urandom);
    rq.remove_count = COUNT_W'($urandom);
    rq.pos_a        = POS_W'($urandom);
    rq.pos_b        = POS_W'($urandom);
    rq.read_index   = INDEX_W'($urandom);
    return rq;
  endfunction

  function automatic list_request_t insert_req(input logic [KIND_W-1:0] kind,
                                               input logic [HANDLE_W-1:0] handle,
                                               input logic [PRICE_W-1:0] price);
    list_request_t rq;
    rq        = scrambled_request(kind);
    rq.handle = handle;
    rq.price  = price;
    return rq;
  endfunction

  function automatic list_request_t swap_req(input int pos_a, input int pos_b);
    list_request_t rq;
    rq       = scrambled_request(OP_SWAP);
    rq.pos_a = POS_W'(pos_a);
    rq.pos_b = POS_W'(pos_b);
    return rq;
  endfunction

  function automatic list_request_t read_req(input int index);
    list_request_t rq;
    rq            = scrambled_request(OP_READ);
    rq.read_index = INDEX_W'(index);
    return rq;
  endfunction

  function automatic list_request_t remove_req(input int count);
    list_request_t rq;
    rq              = scrambled_request(OP_REMOVE);
    rq.remove_count = COUNT_W'(count);
    return rq;
  endfunction

  // Present one request, hold it until accepted, record its result, then
  // idle for a random gap unless running back to back.
  task automatic issue_request(input list_request_t rq);
    list_result_t res;
    int           gap;
    start           <= 1'b1;
    in_kind         <= rq.kind;
    in_item_handle  <= rq.handle;
    in_item_price   <= rq.price;
    in_remove_count <= rq.remove_count;
    in_position_a   <= rq.pos_a;
    in_position_b   <= rq.pos_b;
    in_read_index   <= rq.read_index;
    do @(posedge clk); while (busy);
    res           = apply_list_op(rq);
    res.issued_at = $time;
    pending_outcomes.push_back(res);
    issued_total++;
    gap = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and hold off until every outstanding request has answered.
  task automatic wait_drained();
    start <= 1'b0;
    while (checked_total != issued_total) @(posedge clk);
  endtask

  // Every operation but the inserts against an empty list, plus the unused kind codes.
  task automatic test_empty_list();
    issue_request(remove_req(1));
    issue_request(swap_req(1, 1));
    issue_request(scrambled_request(OP_FIND_MIN));
    issue_request(read_req(0));
    issue_request(scrambled_request(KIND_SPARE_LO));
    issue_request(scrambled_request(KIND_SPARE_HI));
  endtask

  // Field extremes, ties on the minimum, self swap, out-of-range positions,
  // remove zero and remove more than stored.
  task automatic test_basic_ops();
    issue_request(insert_req(OP_INS_BACK, '1, '1));
    issue_request(insert_req(OP_INS_FRONT, '0, '0));
    issue_request(insert_req(OP_INS_BACK, 16'h1234, '0));
    issue_request(scrambled_request(OP_FIND_MIN));
    issue_request(read_req(0));
    issue_request(read_req(2));
    issue_request(read_req(3));
    issue_request(read_req(127));
    issue_request(swap_req(1, 1));
    issue_request(swap_req(1, 3));
    issue_request(scrambled_request(OP_FIND_MIN));
    issue_request(swap_req(0, 2));
    issue_request(swap_req(2, 4));
    issue_request(swap_req(255, 1));
    issue_request(remove_req(0));
    issue_request(scrambled_request(KIND_SPARE_LO));
    issue_request(scrambled_request(KIND_SPARE_HI));
    issue_request(remove_req(255));
    issue_request(remove_req(3));
  endtask

  // Fill to capacity, bounce off the full list, work at the top end, then
  // empty it with an exact-length remove.
  task automatic test_fill_to_capacity();
    logic [KIND_W-1:0] kind;
    wait_drained();
    while (shadow_count < CAPACITY) begin
      kind = $urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_BACK;
      issue_request(insert_req(kind, HANDLE_W'($urandom), PRICE_W'($urandom_range(0, 1023))));
    end
    issue_request(insert_req(OP_INS_FRONT, '1, '1));
    issue_request(insert_req(OP_INS_BACK, '0, '0));
    issue_request(scrambled_request(OP_FIND_MIN));
    issue_request(read_req(CAPACITY - 1));
    issue_request(swap_req(1, CAPACITY));
    issue_request(swap_req(CAPACITY + 1, 1));
    issue_request(read_req(0));
    issue_request(remove_req(CAPACITY));
  endtask

  // Mostly well-formed traffic with random content; the list length wanders
  // between empty and full.
  task automatic test_random_traffic();
    list_request_t rq;
    int            pick;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 150 == 0) back_to_back = ($urandom_range(0, 2) == 0);
      if (n == RANDOM_REQUESTS / 2) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        rq = scrambled_request(OP_INS_FRONT);
      end else if (pick < 47) begin
        rq = scrambled_request(OP_INS_BACK);
      end else if (pick < 55) begin
        rq = scrambled_request(OP_REMOVE);
        if ($urandom_range(0, 7) != 0) rq.remove_count = COUNT_W'($urandom_range(0, 6));
      end else if (pick < 70) begin
        rq = scrambled_request(OP_SWAP);
        if (shadow_count != 0 && $urandom_range(0, 4) != 0) begin
          rq.pos_a = POS_W'($urandom_range(1, shadow_count));
          rq.pos_b = POS_W'($urandom_range(1, shadow_count));
        end
      end else if (pick < 82) begin
        rq = scrambled_request(OP_FIND_MIN);
      end else if (pick < 97) begin
        rq = scrambled_request(OP_READ);
        if (shadow_count != 0 && $urandom_range(0, 6) != 0)
          rq.read_index = INDEX_W'($urandom_range(0, shadow_count - 1));
      end else begin
        rq = scrambled_request($urandom_range(0, 1) ? KIND_SPARE_LO : KIND_SPARE_HI);
      end
      // Narrow prices now and then so the minimum search meets ties.
      if ($urandom_range(0, 2) == 0) rq.price = PRICE_W'($urandom_range(0, 3));
      issue_request(rq);
    end
    back_to_back = 1'b0;
  endtask

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Check each strobed result against the oldest outstanding request. A
  // request accepted at this very edge cannot answer yet, so it does not count as outstanding.
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0 || pending_outcomes[0].issued_at == $time) begin
        $error("result with no request outstanding: ok %0b length %0d", out_ok, out_length);
        mismatch_count++;
      end else begin
        want = pending_outcomes.pop_front();
        compare_field("ok", want.ok, out_ok);
        compare_field("found_handle", want.found_handle, out_found_handle);
        compare_field("found_price", want.found_price, out_found_price);
        compare_field("length", want.length, out_length);
        compare_field("is_empty", want.is_empty, out_is_empty);
        compare_field("is_full", want.is_full, out_is_full);
        checked_total <= checked_total + 1;
      end
    end
  end

  // Abort if neither a request nor a result moves for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_kind         <= '0;
    in_item_handle  <= '0;
    in_item_price   <= '0;
    in_remove_count <= '0;
    in_position_a   <= '0;
    in_position_b   <= '0;
    in_read_index   <= '0;
    shadow_count     = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_basic_ops();
    test_fill_to_capacity();
    test_random_traffic();

    // Let the last results land, then watch for any stray strobe.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bale_pkg.sv
rtl/bale_ctrl.sv
rtl/bale_dpath.sv
rtl/bounded_array_list_engine_unit.sv
rtl/bale_checker.sv
tb/bounded_array_list_engine_unit_tb.sv
